// ----- rtl/core/bblur_pkg.sv -----
// ----------------------------------------------------------------------------
// bblur_pkg: shared types and constants of the 3x3 box blur
// Word types of both channels, register indexes, window control bits and
// the reciprocal table used for the rounded mean.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 4096;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixW    = 3 * ChanW;
  localparam int unsigned FwW     = 12;
  localparam int unsigned FhW     = 13;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned ColSumW = 10;
  localparam int unsigned SumW    = 12;
  localparam int unsigned CntW    = 4;
  localparam int unsigned RecipW  = 16;
  localparam int unsigned RecipSh = 15;

  localparam logic [FwW-1:0] FrameWidthRst  = 12'd640;
  localparam logic [FhW-1:0] FrameHeightRst = 13'd480;

  localparam logic FuncDrain = 1'b1;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic             func;
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
  } in_word_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             end_of_row;
    logic             end_of_frame;
  } out_word_t;

  // Per-column window control: result due, neighbor rows/columns in frame
  typedef struct packed {
    logic due;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic eor;
    logic eof;
  } win_ctl_t;

  // ceil(2^RecipSh / cnt), exact for every sum the window can produce
  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] r;
    case (cnt)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10923;
      4'd4:    r = 16'd8192;
      4'd6:    r = 16'd5462;
      4'd9:    r = 16'd3641;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/box_blur_3x3_rgb_core.sv -----
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core: streaming 3x3 box blur of RGB frames
// Input words carry pixels in raster order (func 0) or drain ticks (func 1).
// Each result is the rounded mean of the in-frame 3x3 neighborhood of one
// pixel, with end_of_row / end_of_frame flags, in raster order.
//
// Both channels use valid/stall. Results trail the input by width+1 words:
// after the last pixel of a frame, send width+1 drain ticks (or pixels,
// whose data is dropped) to push out the tail. A drain tick while idle or
// while pixels are still expected is taken and does nothing.
// One word per cycle is sustained while the output is not stalled. The word
// that completes a result's window passes the input stage with line buffer
// read, the window cells, the sum stage and the output stage. The two prior
// rows live in one RAM with registered read; the input stage reads the column
// while the previous word writes back its column. The user must write
// frame_width / frame_height only while idle; the block does not enforce it.
// They take effect at the next frame start. Reset clears control and the
// registers to 640 x 480; the line buffer keeps its contents. A stalled output
// holds its word; the input stalls only when all four stages are occupied.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core import bblur_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_word_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_word_t       out_data_o,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned ColW = $clog2(MaxWidth);

  logic [FwW-1:0] frame_width_q;
  logic [FhW-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[FwW-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[FhW-1:0];
        default: ;
      endcase
    end
  end

  // Elastic stage control
  logic a_v_q, b_v_q, c_v_q, out_v_q;
  logic out_free, c_move, c_free, b_move, b_free, a_move;
  logic accept;

  assign out_free   = !out_v_q || !out_stall_i;
  assign c_move     = c_v_q && out_free;
  assign c_free     = !c_v_q || out_free;
  assign b_move     = b_v_q && c_free;
  assign b_free     = !b_v_q || c_free;
  assign a_move     = a_v_q && b_free;
  assign in_stall_o = a_v_q && !b_free;
  assign accept     = in_valid_i && !in_stall_o;

  logic            adv;
  logic [PixW-1:0] f_pix;
  logic [ColW-1:0] f_col;
  win_ctl_t        f_ctl;

  bblur_ctrl #(
    .MaxWidth (MaxWidth),
    .MaxHeight(MaxHeight)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_word_i     (in_data_i),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .adv_o         (adv),
    .pix_o         (f_pix),
    .col_o         (f_col),
    .ctl_o         (f_ctl)
  );

  // Stage A: line buffer read
  logic [PixW-1:0]   a_pix_q, a_fwd_up_q, a_fwd_lo_q;
  logic [ColW-1:0]   a_col_q;
  win_ctl_t          a_ctl_q;
  logic              a_fwd_q;
  logic [2*PixW-1:0] rd_data;
  logic [PixW-1:0]   a_up, a_lo;

  assign a_up = a_fwd_q ? a_fwd_up_q : rd_data[2*PixW-1:PixW];
  assign a_lo = a_fwd_q ? a_fwd_lo_q : rd_data[PixW-1:0];

  bblur_ram #(
    .Width(2 * PixW),
    .Depth(MaxWidth)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (a_move),
    .waddr_i(a_col_q),
    .wdata_i({a_lo, a_pix_q}),
    .re_i   (adv),
    .raddr_i(f_col),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= 1'b1;
    end else if (a_move) begin
      a_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_pix_q    <= f_pix;
      a_col_q    <= f_col;
      a_ctl_q    <= f_ctl;
      // Same column written back this cycle: take the new word, not the RAM
      a_fwd_q    <= a_move && (f_col == a_col_q);
      a_fwd_up_q <= a_lo;
      a_fwd_lo_q <= a_pix_q;
    end
  end

  // Stage B: window cells
  win_ctl_t b_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (a_move) begin
      b_v_q <= a_ctl_q.due;
    end else if (b_move) begin
      b_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_ctl_q <= a_ctl_q;
    end
  end

  logic [2:0][PixW-1:0]    cell_in  [3];
  logic [2:0][PixW-1:0]    cell_out [3];
  logic [2:0][ColSumW-1:0] cell_sum [3];
  logic [2:0]              row_en, col_en;

  assign row_en = {b_ctl_q.bot_ok, 1'b1, b_ctl_q.top_ok};
  assign col_en = {b_ctl_q.right_ok, 1'b1, b_ctl_q.left_ok};

  for (genvar k = 0; k < 3; k++) begin : g_cell
    if (k == 2) begin : g_head
      assign cell_in[k] = {a_pix_q, a_lo, a_up};
    end else begin : g_link
      assign cell_in[k] = cell_out[k+1];
    end
    bblur_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (a_move),
      .col_i   (cell_in[k]),
      .col_o   (cell_out[k]),
      .row_en_i(row_en),
      .col_en_i(col_en[k]),
      .sum_o   (cell_sum[k])
    );
  end

  // Stage C: window sums and neighbor count
  logic [2:0][SumW-1:0] c_sum_q;
  logic [CntW-1:0]      c_cnt_q;
  logic                 c_eor_q, c_eof_q;
  logic [1:0]           n_rows, n_cols;
  logic [CntW-1:0]      b_cnt;

  assign n_rows = 2'd1 + 2'(b_ctl_q.top_ok) + 2'(b_ctl_q.bot_ok);
  assign n_cols = 2'd1 + 2'(b_ctl_q.left_ok) + 2'(b_ctl_q.right_ok);
  assign b_cnt  = CntW'(n_rows) * CntW'(n_cols);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (b_move) begin
      c_v_q <= 1'b1;
    end else if (c_move) begin
      c_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      for (int ch = 0; ch < 3; ch++) begin
        c_sum_q[ch] <= SumW'(cell_sum[0][ch]) + SumW'(cell_sum[1][ch])
                     + SumW'(cell_sum[2][ch]);
      end
      c_cnt_q <= b_cnt;
      c_eor_q <= b_ctl_q.eor;
      c_eof_q <= b_ctl_q.eof;
    end
  end

  // Output stage: rounded mean
  logic [2:0][ChanW-1:0] mean;
  out_word_t             out_q;

  for (genvar ch = 0; ch < 3; ch++) begin : g_mean
    bblur_mean u_mean (
      .sum_i (c_sum_q[ch]),
      .cnt_i (c_cnt_q),
      .mean_o(mean[ch])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (c_move) begin
      out_v_q <= 1'b1;
    end else if (out_free) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_move) begin
      out_q.out_red      <= mean[2];
      out_q.out_green    <= mean[1];
      out_q.out_blue     <= mean[0];
      out_q.end_of_row   <= c_eor_q;
      out_q.end_of_frame <= c_eof_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/bblur_ram.sv -----
// ----------------------------------------------------------------------------
// bblur_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data and a read
// enable that holds the data register.
// ----------------------------------------------------------------------------
module bblur_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bblur_ctrl.sv -----
// ----------------------------------------------------------------------------
// bblur_ctrl: frame tracking and window control
// Tracks input and output positions of the frame, latches the frame size at
// frame start and decides per accepted word whether the window advances and
// which neighbors of the due result lie inside the frame.
// ----------------------------------------------------------------------------
module bblur_ctrl import bblur_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef,
  localparam int unsigned ColW = $clog2(MaxWidth),
  localparam int unsigned WdW  = $clog2(MaxWidth + 1),
  localparam int unsigned HtW  = $clog2(MaxHeight + 1),
  localparam int unsigned RowW = $clog2(MaxHeight + 2)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  in_word_t        in_word_i,
  input  logic [FwW-1:0]  frame_width_i,
  input  logic [FhW-1:0]  frame_height_i,
  output logic            adv_o,
  output logic [PixW-1:0] pix_o,
  output logic [ColW-1:0] col_o,
  output win_ctl_t        ctl_o
);

  logic            busy_q, busy_d;
  logic [WdW-1:0]  act_w_q, act_w_d;
  logic [HtW-1:0]  act_h_q, act_h_d;
  logic [ColW-1:0] ic_q, ic_d, oc_q, oc_d;
  logic [RowW-1:0] ir_q, ir_d, or_q, or_d;

  logic [WdW-1:0]  clamp_w, e_w;
  logic [HtW-1:0]  clamp_h, e_h;
  logic [ColW-1:0] e_ic, e_oc;
  logic [RowW-1:0] e_ir, e_or;
  logic            drain, start, pixel_phase, due, in_wrap, eor, last_row;
  logic [ColW:0]   ic_inc, oc_inc;
  logic [RowW:0]   or_inc;

  always_comb begin
    if (frame_width_i == '0) begin
      clamp_w = WdW'(1);
    end else if (32'(frame_width_i) > MaxWidth) begin
      clamp_w = WdW'(MaxWidth);
    end else begin
      clamp_w = WdW'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      clamp_h = HtW'(1);
    end else if (32'(frame_height_i) > MaxHeight) begin
      clamp_h = HtW'(MaxHeight);
    end else begin
      clamp_h = HtW'(frame_height_i);
    end
  end

  assign drain       = (in_word_i.func == FuncDrain);
  assign start       = accept_i && !busy_q && !drain;
  assign pixel_phase = busy_q && (ir_q < RowW'(act_h_q));
  // Past the last row every word pushes a zero column through the window
  assign adv_o = accept_i && (busy_q ? (!pixel_phase || !drain) : !drain);
  assign pix_o = (busy_q && !pixel_phase) ? '0
               : {in_word_i.in_red, in_word_i.in_green, in_word_i.in_blue};

  assign e_w  = start ? clamp_w : act_w_q;
  assign e_h  = start ? clamp_h : act_h_q;
  assign e_ic = start ? '0 : ic_q;
  assign e_ir = start ? '0 : ir_q;
  assign e_oc = start ? '0 : oc_q;
  assign e_or = start ? '0 : or_q;

  assign due      = (e_ir >= RowW'(2)) || ((e_ir == RowW'(1)) && (e_ic != '0));
  assign ic_inc   = {1'b0, e_ic} + (ColW + 1)'(1);
  assign in_wrap  = ic_inc >= (ColW + 1)'(e_w);
  assign oc_inc   = {1'b0, e_oc} + (ColW + 1)'(1);
  assign eor      = oc_inc >= (ColW + 1)'(e_w);
  assign or_inc   = {1'b0, e_or} + (RowW + 1)'(1);
  assign last_row = or_inc >= (RowW + 1)'(e_h);

  assign col_o          = e_ic;
  assign ctl_o.due      = due;
  assign ctl_o.top_ok   = (e_or != '0);
  assign ctl_o.bot_ok   = !last_row;
  assign ctl_o.left_ok  = (e_oc != '0);
  assign ctl_o.right_ok = !eor;
  assign ctl_o.eor      = eor;
  assign ctl_o.eof      = eor && last_row;

  always_comb begin
    busy_d  = busy_q;
    act_w_d = act_w_q;
    act_h_d = act_h_q;
    ic_d    = ic_q;
    ir_d    = ir_q;
    oc_d    = oc_q;
    or_d    = or_q;
    if (start) begin
      busy_d  = 1'b1;
      act_w_d = clamp_w;
      act_h_d = clamp_h;
    end
    if (adv_o) begin
      ic_d = in_wrap ? '0 : ic_inc[ColW-1:0];
      ir_d = in_wrap ? e_ir + RowW'(1) : e_ir;
      if (due) begin
        oc_d = eor ? '0 : oc_inc[ColW-1:0];
        or_d = eor ? or_inc[RowW-1:0] : e_or;
        if (eor && last_row) begin
          busy_d = 1'b0;
        end
      end else begin
        oc_d = e_oc;
        or_d = e_or;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      act_w_q <= WdW'(640);
      act_h_q <= HtW'(480);
      ic_q    <= '0;
      ir_q    <= '0;
      oc_q    <= '0;
      or_q    <= '0;
    end else begin
      busy_q  <= busy_d;
      act_w_q <= act_w_d;
      act_h_q <= act_h_d;
      ic_q    <= ic_d;
      ir_q    <= ir_d;
      oc_q    <= oc_d;
      or_q    <= or_d;
    end
  end

endmodule

// ----- rtl/core/bblur_cell.sv -----
// ----------------------------------------------------------------------------
// bblur_cell: one column of the 3x3 window
// Holds three pixels of one column, takes the column of its right neighbor
// on each shift and gives the per-channel sum of its in-frame pixels.
// ----------------------------------------------------------------------------
module bblur_cell import bblur_pkg::*; (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic [2:0][PixW-1:0]          col_i,
  output logic [2:0][PixW-1:0]          col_o,
  input  logic [2:0]                    row_en_i,
  input  logic                          col_en_i,
  output logic [2:0][ColSumW-1:0]       sum_o
);

  logic [2:0][PixW-1:0] col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

  // Channel 2 is red, 1 green, 0 blue
  always_comb begin
    logic [ColSumW-1:0] acc;
    for (int ch = 0; ch < 3; ch++) begin
      acc = '0;
      for (int r = 0; r < 3; r++) begin
        if (row_en_i[r] && col_en_i) begin
          acc = acc + ColSumW'(col_q[r][ch*ChanW +: ChanW]);
        end
      end
      sum_o[ch] = acc;
    end
  end

endmodule

// ----- rtl/core/bblur_mean.sv -----
// ----------------------------------------------------------------------------
// bblur_mean: rounded mean of one channel
// Gives floor(sum / cnt + 1/2) as (sum + cnt/2) times a reciprocal of cnt.
// ----------------------------------------------------------------------------
module bblur_mean import bblur_pkg::*; (
  input  logic [SumW-1:0]  sum_i,
  input  logic [CntW-1:0]  cnt_i,
  output logic [ChanW-1:0] mean_o
);

  logic [SumW-1:0]        num;
  logic [SumW+RecipW-1:0] prod;

  assign num    = sum_i + SumW'(cnt_i >> 1);
  assign prod   = (SumW + RecipW)'(num) * (SumW + RecipW)'(recip(cnt_i));
  assign mean_o = prod[RecipSh +: ChanW];

endmodule

// ----- rtl/core/bblur_chk.sv -----
// ----------------------------------------------------------------------------
// bblur_chk: port-level checks of the box blur core
// Watches the handshake and result flags on the top-level ports.
// ----------------------------------------------------------------------------
module bblur_chk import bblur_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // The last pixel of a frame is also the last of its row
  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.end_of_frame || out_data_o.end_of_row))
    else $error("end_of_frame without end_of_row");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output side is free");

endmodule

bind box_blur_3x3_rgb_core bblur_chk u_bblur_chk (.*);
